// File: rtl/sss_pkg.sv
// Shared types and codes for the sorted set store.
package sss_pkg;

  localparam int SSS_CAPACITY = 16;
  localparam int VAL_W        = 32;

  // input operation selector
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LIST   = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_LIST     = 3'd4
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic signed [31:0] value;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

endpackage

// File: rtl/sorted_set_store_core.sv
// Top level of the sorted set store: cell chain, control and result register.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a
// chain of cells. Input transfers on in_*: func selects insert, delete or
// listing, value is the operand. Each insert or delete gives one result
// transfer on out_* with a status; a listing gives every stored value in
// ascending order as a run closed by out_tlast, or one empty marker.
// Func 3 is accepted and gives nothing.
// Insert and delete finish in the cycle of their transfer: every cell
// compares against the operand at once and shifts from its neighbour, so
// one item per cycle while the result register drains. The result is
// registered and appears in the cycle after the input transfer.
// A listing of N values keeps the input closed: the state moves to listing,
// then each value goes from cell 0 into the result register as the chain
// rotates towards cell 0, whenever that register drains; no input is taken
// until the last value is loaded. An empty listing behaves like an insert.
// While a result waits with out_tready low, it holds and in_tready drops.
// After reset the store is empty; the cell contents need no clearing.
module sorted_set_store_core #(
  parameter int CAPACITY = sss_pkg::SSS_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] func, [33:2] value, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] entry, [32] has_entry, [35:33] status
  output logic        out_tlast
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  sss_pkg::state_t     state_r, state_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [OCC_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  entry_r, entry_nxt;
  logic                has_r, has_nxt;
  sss_pkg::status_t    status_r, status_nxt;
  logic                last_r, last_nxt;

  sss_pkg::func_t      in_func;
  logic signed [31:0]  in_value;
  logic                in_fire;
  logic                slot_free;
  logic                found;
  logic                full;
  logic                list_last;

  sss_pkg::cell_cmd_t  cmd;
  logic signed [31:0]  cell_val [CAPACITY];
  logic                cell_lt  [CAPACITY];
  logic [CAPACITY-1:0] cell_eq;

  assign in_func   = sss_pkg::func_t'(in_tdata[1:0]);
  assign in_value  = in_tdata[33:2];
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == sss_pkg::S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign found     = |cell_eq;
  assign full      = occ_r == OCC_W'(CAPACITY);
  assign list_last = cnt_r == OCC_W'(occ_r - 1'b1);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv;
    logic               llt;
    logic signed [31:0] rv;
    if (i == 0) begin : g_head
      assign lv  = cell_val[0];
      assign llt = 1'b1;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign llt = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_body
      assign rv = cell_val[i+1];
    end
    sss_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ_r),
      .left_val  (lv),
      .left_lt   (llt),
      .right_val (rv),
      .head_val  (cell_val[0]),
      .val       (cell_val[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sss_pkg::S_IDLE: begin
        if (in_fire && in_func == sss_pkg::FN_LIST && occ_r != '0) state_nxt = sss_pkg::S_LIST;
      end
      sss_pkg::S_LIST: begin
        if (slot_free && list_last) state_nxt = sss_pkg::S_IDLE;
      end
      default: state_nxt = sss_pkg::S_IDLE;
    endcase
  end

  // outputs, chain command, counters
  always_comb begin
    cmd.op        = sss_pkg::CELL_HOLD;
    cmd.value     = in_value;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    entry_nxt     = entry_r;
    has_nxt       = has_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    case (state_r)
      sss_pkg::S_IDLE: begin
        if (in_fire) begin
          entry_nxt = '0;
          has_nxt   = 1'b0;
          last_nxt  = 1'b1;
          cnt_nxt   = '0;
          case (in_func)
            sss_pkg::FN_INSERT: begin
              out_valid_nxt = 1'b1;
              if (found) begin
                status_nxt = sss_pkg::ST_DUP;
              end else if (full) begin
                status_nxt = sss_pkg::ST_FULL;
              end else begin
                status_nxt = sss_pkg::ST_DONE;
                cmd.op     = sss_pkg::CELL_INSERT;
                occ_nxt    = occ_r + 1'b1;
              end
            end
            sss_pkg::FN_DELETE: begin
              out_valid_nxt = 1'b1;
              if (found) begin
                status_nxt = sss_pkg::ST_DONE;
                cmd.op     = sss_pkg::CELL_DELETE;
                occ_nxt    = occ_r - 1'b1;
              end else begin
                status_nxt = sss_pkg::ST_NOTFOUND;
              end
            end
            sss_pkg::FN_LIST: begin
              // empty store gives the single marker; otherwise the run follows
              status_nxt    = sss_pkg::ST_LIST;
              out_valid_nxt = occ_r == '0;
            end
            default: ;
          endcase
        end
      end
      sss_pkg::S_LIST: begin
        if (slot_free) begin
          cmd.op        = sss_pkg::CELL_ROTATE;
          out_valid_nxt = 1'b1;
          entry_nxt     = cell_val[0];
          has_nxt       = 1'b1;
          status_nxt    = sss_pkg::ST_LIST;
          last_nxt      = list_last;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sss_pkg::S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r  <= entry_nxt;
    has_r    <= has_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, status_r, has_r, entry_r};
  assign out_tlast  = last_r;

endmodule

// File: rtl/sss_cell.sv
// One storage cell of the sorted chain: holds a value, compares, shifts.
module sss_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic                     clk,
  input  sss_pkg::cell_cmd_t       cmd,
  input  logic [OCC_W-1:0]         occ,
  input  logic signed [31:0]       left_val,   // value of cell IDX-1
  input  logic                     left_lt,    // cell IDX-1 holds a smaller value
  input  logic signed [31:0]       right_val,  // value of cell IDX+1
  input  logic signed [31:0]       head_val,   // value of cell 0
  output logic signed [31:0]       val,
  output logic                     lt,
  output logic                     eq
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               occupied;
  logic               is_end;

  assign occupied = OCC_W'(IDX) < occ;
  assign is_end   = OCC_W'(IDX + 1) == occ;
  assign lt       = occupied && (val_r < cmd.value);
  assign eq       = occupied && (val_r == cmd.value);
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      sss_pkg::CELL_INSERT: begin
        // cells at or above the insert point move up one place
        if (!lt) val_nxt = left_lt ? cmd.value : left_val;
      end
      sss_pkg::CELL_DELETE: begin
        if (!lt) val_nxt = right_val;
      end
      sss_pkg::CELL_ROTATE: begin
        // circular shift down over the occupied slots
        val_nxt = is_end ? head_val : right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/sss_chk.sv
// Port-level checks for the sorted set store, bound to the top level.
module sss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a stored value only appears in a listing
  a_entry_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[35:33] == sss_pkg::ST_LIST)
    else $error("entry flagged outside a listing");

  // without an entry the entry field is zero and the result closes its run
  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'd0 && out_tlast)
    else $error("empty result malformed");

  // no input taken while a listing run is still open
  a_list_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] && !out_tlast |-> !in_tready)
    else $error("input taken during listing");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_set_store_core sss_chk u_sss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: verif/sorted_set_store_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted set store core: directed and random traffic.
module sorted_set_store_core_tb;
  import sss_pkg::*;

  localparam int CAP   = SSS_CAPACITY;
  localparam int PAD_W = 40 - 2 - VAL_W;

  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

  // one result transfer as the store should give it
  typedef struct {
    logic signed [VAL_W-1:0] entry;
    logic                    has_entry;
    status_t                 status;
    logic                    last;
  } store_reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // [1:0] func, [33:2] value, rest zero
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [31:0] entry, [32] has_entry, [35:33] status
  logic        out_tlast;

  // shadow copy of the stored values, ascending, and the replies still owed
  logic signed [VAL_W-1:0] shadow_set[$];
  store_reply_t            due_replies[$];

  int n_errors     = 0;
  bit src_pause_en = 1'b1;
  bit snk_pause_en = 1'b1;

  sorted_set_store_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void queue_reply(logic signed [VAL_W-1:0] entry, logic has_entry,
                                      status_t status, logic last);
    store_reply_t r;
    r.entry     = entry;
    r.has_entry = has_entry;
    r.status    = status;
    r.last      = last;
    due_replies.push_back(r);
  endfunction

  // Apply one command to the shadow set and queue the replies it owes.
  function automatic void shadow_store_op(func_t fn, logic signed [VAL_W-1:0] v);
    int pos;
    bit hit;
    pos = 0;
    while (pos < shadow_set.size() && shadow_set[pos] < v) pos++;
    hit = (pos < shadow_set.size()) && (shadow_set[pos] == v);
    case (fn)
      FN_INSERT: begin
        // a value already held reports duplicate even when full
        if (hit) begin
          queue_reply('0, 1'b0, ST_DUP, 1'b1);
        end else if (shadow_set.size() >= CAP) begin
          queue_reply('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          shadow_set.insert(pos, v);
          queue_reply('0, 1'b0, ST_DONE, 1'b1);
        end
      end
      FN_DELETE: begin
        if (hit) begin
          shadow_set.delete(pos);
          queue_reply('0, 1'b0, ST_DONE, 1'b1);
        end else begin
          queue_reply('0, 1'b0, ST_NOTFOUND, 1'b1);
        end
      end
      FN_LIST: begin
        // empty store gives a single marker with no entry
        if (shadow_set.size() == 0) begin
          queue_reply('0, 1'b0, ST_LIST, 1'b1);
        end else begin
          foreach (shadow_set[i])
            queue_reply(shadow_set[i], 1'b1, ST_LIST, i == shadow_set.size() - 1);
        end
      end
      default: ;  // unused selector: swallowed, nothing changes
    endcase
  endfunction

  // Offer one command, after a random gap, and hold it until the transfer.
  // tvalid stays high on return so back-to-back commands need no extra edge.
  task automatic push_command(func_t fn, logic signed [VAL_W-1:0] v);
    int gap;
    gap = src_pause_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{PAD_W{1'b0}}, v, fn};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    shadow_store_op(fn, v);
  endtask

  // Stop offering, wait for every owed reply, then allow for swallowed commands.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_errors++;
    end
  endfunction

  // Result side: random back-pressure per transfer, each transfer checked
  // against the oldest owed reply.
  initial begin : reply_checker
    int           stall;
    store_reply_t want;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = snk_pause_en ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (due_replies.size() == 0) begin
        $error("reply with none owed: tdata %h, tlast %b", out_tdata, out_tlast);
        n_errors++;
      end else begin
        want = due_replies.pop_front();
        check_field("entry", want.entry, out_tdata[31:0]);
        check_field("has_entry", want.has_entry, out_tdata[32]);
        check_field("status", want.status, out_tdata[35:33]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // Empty store: listing marker, delete miss, unused selector.
  task automatic test_empty_store();
    push_command(FN_LIST, $urandom);
    push_command(FN_DELETE, 5);
    push_command(FN_UNUSED, $urandom);
  endtask

  // Signed extremes and ordering, duplicate insert, delete hit and miss.
  // Run without any idling on either side.
  task automatic test_extreme_values();
    src_pause_en = 1'b0;
    snk_pause_en = 1'b0;
    push_command(FN_INSERT, MAX_VAL);
    push_command(FN_INSERT, MIN_VAL);
    push_command(FN_INSERT, 0);
    push_command(FN_INSERT, -1);
    push_command(FN_INSERT, MIN_VAL);
    push_command(FN_LIST, $urandom);
    push_command(FN_DELETE, MIN_VAL);
    push_command(FN_DELETE, 7);
  endtask

  // Fill to capacity with even values, then an odd (absent) value is dropped,
  // a held value still reports duplicate, and a full listing runs.
  task automatic test_full_store();
    src_pause_en = 1'b1;
    snk_pause_en = 1'b1;
    while (shadow_set.size() < CAP) push_command(FN_INSERT, $urandom & 32'hFFFF_FFFE);
    push_command(FN_INSERT, 3);
    push_command(FN_INSERT, 0);
    push_command(FN_LIST, $urandom);
  endtask

  // Alternating grow and shrink phases over a small value pool so that
  // duplicates, full drops, delete hits and misses all recur; one in ten
  // values is drawn from the whole range.
  task automatic test_random_traffic(int n_items);
    logic signed [VAL_W-1:0] pool[24];
    logic signed [VAL_W-1:0] v;
    int                      n_done;
    int                      phase_left;
    int                      pick;
    bit                      growing;
    func_t                   fn;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0]    = MIN_VAL;
    pool[1]    = MAX_VAL;
    pool[2]    = 0;
    pool[3]    = -1;
    n_done     = 0;
    phase_left = 0;
    growing    = 1'b0;
    while (n_done < n_items) begin
      if (phase_left == 0) begin
        phase_left   = $urandom_range(20, 60);
        growing      = !growing;
        src_pause_en = $urandom_range(0, 3) != 0;
        snk_pause_en = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) fn = FN_UNUSED;
      else if (pick < 10) fn = FN_LIST;
      else if ((pick < 75) == growing) fn = FN_INSERT;
      else fn = FN_DELETE;
      if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = pool[$urandom_range(0, 23)];
      push_command(fn, v);
      if (fn != FN_UNUSED) begin
        n_done++;
        phase_left--;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_extreme_values();
    test_full_store();
    test_random_traffic(380);
    settle();
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sorted_set_store_core.f
rtl/sss_pkg.sv
rtl/sss_cell.sv
rtl/sorted_set_store_core.sv
rtl/sss_chk.sv
verif/sorted_set_store_core_tb.sv
